// File: sv/fcpt_pkg.sv
// Shared constants, types and codes of the four-channel periodic timer.
package fcpt_pkg;

    // Block dimensions
    localparam int CHANNELS     = 4;
    localparam int REGION_BYTES = 4096;
    localparam int ROWS         = REGION_BYTES / 4;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Stream payload widths
    localparam int IN_W  = 112;
    localparam int OUT_W = 40;

    // Register map
    localparam logic [11:0] CH_BASE    = 12'h020;
    localparam logic [11:0] CH_END     = 12'(32'h20 + 32'h10 * CHANNELS);
    localparam logic [11:0] OFF_MCR    = 12'h008;
    localparam logic [11:0] OFF_MSR    = 12'h00C;
    localparam logic [11:0] OFF_MIER   = 12'h010;
    localparam logic [11:0] OFF_SETTEN = 12'h014;
    localparam logic [11:0] OFF_CLRTEN = 12'h018;
    localparam logic [3:0]  CO_RELOAD  = 4'h0;
    localparam logic [3:0]  CO_COUNT   = 4'h4;
    localparam logic [3:0]  CO_CTRL    = 4'h8;

    // Control word bits
    localparam int EN_BIT    = 0;
    localparam int CHAIN_BIT = 1;

    typedef enum logic [1:0] {
        OP_RD   = 2'd0,
        OP_WR   = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    // What an accepted item does
    typedef enum logic [3:0] {
        K_NONE,
        K_STRD,
        K_STWR,
        K_CHRD,
        K_CHRL,
        K_CHCT,
        K_MSRCLR,
        K_SETEN,
        K_CLREN,
        K_TICK
    } t_kind;

    // One channel memory entry
    typedef struct packed {
        logic [31:0] control;
        logic [31:0] count;
        logic [31:0] reload;
    } t_chan;

    // Backing store request; read and write never share a cycle
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [11:0] off;
        logic [2:0]  size;
        logic [31:0] wdata;
    } t_st_req;

endpackage

// File: sv/fcpt_ram.sv
// Generic simple dual-port RAM with registered read and read enable.
module fcpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port, and read port that holds its data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: sv/fcpt_store.sv
// Byte backing store: four byte banks, steering of unaligned accesses.
module fcpt_store (
    input  logic             i_clk,
    input  fcpt_pkg::t_st_req i_req,
    output logic [31:0]      o_rdata
);

    logic [7:0] w_q [4];
    logic [1:0] r_lo;
    logic [2:0] r_size;

    // Bank b holds the bytes whose offset ends in b; each access hits a bank at most once
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]                 w_k;
        logic [12:0]                w_addr;
        logic                       w_act;
        logic [fcpt_pkg::ROW_W-1:0] w_row;

        assign w_k    = 2'(b) - i_req.off[1:0];
        assign w_addr = 13'(i_req.off) + 13'(w_k);
        assign w_act  = {1'b0, w_k} < i_req.size;
        assign w_row  = w_addr[fcpt_pkg::ROW_W+1:2];

        fcpt_ram #(
            .WIDTH (8),
            .DEPTH (fcpt_pkg::ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (i_req.wr && w_act),
            .i_waddr (w_row),
            .i_wdata (i_req.wdata[8*w_k +: 8]),
            .i_re    (i_req.rd && w_act),
            .i_raddr (w_row),
            .o_rdata (w_q[b])
        );
    end

    // Remember the shape of the pending read
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_lo   <= i_req.off[1:0];
            r_size <= i_req.size;
        end
    end

    // Reassemble little-endian bytes, zero above the access size
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_rdata[8*k +: 8] = (3'(k) < r_size) ? w_q[2'(r_lo + 2'(k))] : 8'h00;
        end
    end

endmodule

// File: sv/fcpt_chan_upd.sv
// Read-modify-write update of one channel entry.
module fcpt_chan_upd (
    input  fcpt_pkg::t_kind i_kind,
    input  fcpt_pkg::t_chan i_ch,
    input  logic [31:0]     i_data,
    input  logic [31:0]     i_step,
    input  logic            i_sel,
    output fcpt_pkg::t_chan o_ch,
    output logic            o_flag
);

    always_comb begin
        o_ch   = i_ch;
        o_flag = 1'b0;
        unique case (i_kind)
            // Reload write also loads a stopped channel's count
            fcpt_pkg::K_CHRL: begin
                o_ch.reload = i_data;
                if (!i_ch.control[fcpt_pkg::EN_BIT]) begin
                    o_ch.count = i_data;
                end
            end
            fcpt_pkg::K_CHCT: begin
                o_ch.control = i_data;
                if (i_data[fcpt_pkg::EN_BIT] && i_ch.count == 32'h0) begin
                    o_ch.count = i_ch.reload;
                end
            end
            fcpt_pkg::K_SETEN: begin
                if (i_sel) begin
                    o_ch.control[fcpt_pkg::EN_BIT] = 1'b1;
                    if (i_ch.count == 32'h0) begin
                        o_ch.count = i_ch.reload;
                    end
                end
            end
            fcpt_pkg::K_CLREN: begin
                if (i_sel) begin
                    o_ch.control[fcpt_pkg::EN_BIT] = 1'b0;
                end
            end
            // Count an enabled, unchained channel down, or reload and flag it on expiry
            fcpt_pkg::K_TICK: begin
                if (i_ch.control[fcpt_pkg::EN_BIT] && !i_ch.control[fcpt_pkg::CHAIN_BIT]) begin
                    if (i_ch.count > i_step) begin
                        o_ch.count = i_ch.count - i_step;
                    end else begin
                        o_ch.count = i_ch.reload;
                        o_flag     = 1'b1;
                    end
                end
            end
            default: begin
                o_ch = i_ch;
            end
        endcase
    end

endmodule

// File: sv/four_channel_periodic_timer.sv
// Four-channel periodic timer: a plain read or write issues any channel memory or byte bank
// read on acceptance, then any write in the work state, where its result is registered once
// the output register is free. Tick, set-enable and clear-enable sweep the channel memory one
// channel per cycle, the last one only once the output register is free. A new item enters
// only once the last is done; the output register lets it enter while a result waits. After
// reset a clearing pass zeroes every store row and channel entry, without input.
module four_channel_periodic_timer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // offset[11:0], access_size[14:12], write_data[46:15], tick_cycles[110:47],
    // clock_ready[111]
    input  logic [fcpt_pkg::IN_W-1:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // read_data[31:0], ok[32], irq_set[33], zero pad[39:34]
    output logic [fcpt_pkg::OUT_W-1:0] o_m_axis_tdata
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WORK  = 4'b0100,
        S_SWEEP = 4'b1000
    } t_state;

    localparam logic [fcpt_pkg::CH_W-1:0] LAST_CH = fcpt_pkg::CH_W'(fcpt_pkg::CHANNELS - 1);

    // Input fields
    fcpt_pkg::t_op w_op;
    logic [11:0]   w_off;
    logic [2:0]    w_size;
    logic [31:0]   w_wdata;
    logic [63:0]   w_cycles;
    logic          w_ready;

    assign w_op     = fcpt_pkg::t_op'(i_s_axis_tuser);
    assign w_off    = i_s_axis_tdata[11:0];
    assign w_size   = i_s_axis_tdata[14:12];
    assign w_wdata  = i_s_axis_tdata[46:15];
    assign w_cycles = i_s_axis_tdata[110:47];
    assign w_ready  = i_s_axis_tdata[111];

    // Registers
    t_state                    r_state, n_state;
    logic [fcpt_pkg::ROW_W-1:0] r_clr_row, n_clr_row;
    logic                      r_ovalid, n_ovalid;
    logic [33:0]               r_odata, n_odata;
    logic                      r_mcr0, n_mcr0;
    logic [7:0]                r_b0c, n_b0c;
    logic [3:0]                r_mier, n_mier;
    fcpt_pkg::t_kind           r_kind, n_kind;
    logic                      r_ok, n_ok;
    logic [11:0]               r_off, n_off;
    logic [2:0]                r_size, n_size;
    logic [31:0]               r_wdata, n_wdata;
    logic [31:0]               r_step, n_step;
    logic [fcpt_pkg::CH_W-1:0] r_ch, n_ch;
    logic [fcpt_pkg::CH_W-1:0] r_idx, n_idx;
    logic [fcpt_pkg::CHANNELS-1:0] r_flags, n_flags;

    // Decode
    fcpt_pkg::t_kind           w_kind;
    logic                      w_acc_ok;
    logic                      w_full;
    logic                      w_ch_hit;
    logic [11:0]               w_ch_off;
    logic [fcpt_pkg::CH_W-1:0] w_ch;
    logic [3:0]                w_co;

    // Memories and update unit
    fcpt_pkg::t_st_req         w_st_req;
    logic [31:0]               w_st_rdata;
    logic                      w_ch_we, w_ch_re;
    logic [fcpt_pkg::CH_W-1:0] w_ch_waddr, w_ch_raddr;
    fcpt_pkg::t_chan           w_ch_wdata, w_ch_q, w_upd;
    logic [$bits(fcpt_pkg::t_chan)-1:0] w_ch_rdata;
    logic                      w_flag;
    logic [fcpt_pkg::CHANNELS-1:0] w_mask, w_flags_new;
    logic [7:0]                w_msr_new;
    logic                      w_slot_free;
    logic                      w_accept;
    logic                      w_last;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'b0, r_odata};
    assign w_slot_free     = !r_ovalid || i_m_axis_tready;
    assign w_ch_q          = fcpt_pkg::t_chan'(w_ch_rdata);
    assign w_mask          = r_wdata[fcpt_pkg::CHANNELS-1:0];
    assign w_flags_new     = r_flags | (w_flag ? (fcpt_pkg::CHANNELS'(1) << r_idx) : '0);
    assign w_msr_new       = r_b0c | 8'(w_flags_new);
    assign w_last          = (r_idx == LAST_CH);

    // Classify the incoming item
    assign w_full   = (w_size == 3'd4);
    assign w_ch_hit = (w_off >= fcpt_pkg::CH_BASE) && (w_off < fcpt_pkg::CH_END);
    assign w_ch_off = w_off - fcpt_pkg::CH_BASE;
    assign w_ch     = w_ch_off[fcpt_pkg::CH_W+3:4];
    assign w_co     = w_off[3:0];
    assign w_acc_ok = (w_op == fcpt_pkg::OP_RD || w_op == fcpt_pkg::OP_WR) &&
                      (w_size != 3'd0) && (w_size <= 3'd4) && w_ready &&
                      ((13'(w_off) + 13'(w_size)) <= 13'(fcpt_pkg::REGION_BYTES));

    always_comb begin
        priority if (w_op == fcpt_pkg::OP_TICK) begin
            w_kind = (w_ready && r_mcr0 && (w_cycles != 64'h0)) ?
                     fcpt_pkg::K_TICK : fcpt_pkg::K_NONE;
        end else if (!w_acc_ok) begin
            w_kind = fcpt_pkg::K_NONE;
        end else if (w_op == fcpt_pkg::OP_RD) begin
            w_kind = (w_full && w_ch_hit && (w_co == fcpt_pkg::CO_RELOAD ||
                      w_co == fcpt_pkg::CO_COUNT || w_co == fcpt_pkg::CO_CTRL)) ?
                     fcpt_pkg::K_CHRD : fcpt_pkg::K_STRD;
        end else if (w_full && w_ch_hit && w_co == fcpt_pkg::CO_RELOAD) begin
            w_kind = fcpt_pkg::K_CHRL;
        end else if (w_full && w_ch_hit && w_co == fcpt_pkg::CO_CTRL) begin
            w_kind = fcpt_pkg::K_CHCT;
        end else if (w_full && w_off == fcpt_pkg::OFF_MSR) begin
            w_kind = fcpt_pkg::K_MSRCLR;
        end else if (w_full && w_off == fcpt_pkg::OFF_SETTEN) begin
            w_kind = fcpt_pkg::K_SETEN;
        end else if (w_full && w_off == fcpt_pkg::OFF_CLRTEN) begin
            w_kind = fcpt_pkg::K_CLREN;
        end else begin
            w_kind = fcpt_pkg::K_STWR;
        end
    end

    // Sequencer: issue reads on acceptance, modify and write back in the work or sweep state
    always_comb begin
        n_state    = r_state;
        n_clr_row  = r_clr_row;
        n_ovalid   = r_ovalid;
        n_odata    = r_odata;
        n_kind     = r_kind;
        n_ok       = r_ok;
        n_off      = r_off;
        n_size     = r_size;
        n_wdata    = r_wdata;
        n_step     = r_step;
        n_ch       = r_ch;
        n_idx      = r_idx;
        n_flags    = r_flags;
        w_st_req   = '0;
        w_ch_we    = 1'b0;
        w_ch_re    = 1'b0;
        w_ch_waddr = '0;
        w_ch_raddr = '0;
        w_ch_wdata = w_upd;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            // Zero one row of every bank per cycle, channel entries on the way
            S_CLEAR: begin
                w_st_req.wr   = 1'b1;
                w_st_req.off  = 12'({r_clr_row, 2'b00});
                w_st_req.size = 3'd4;
                w_ch_we       = (r_clr_row < fcpt_pkg::ROW_W'(fcpt_pkg::CHANNELS));
                w_ch_waddr    = r_clr_row[fcpt_pkg::CH_W-1:0];
                w_ch_wdata    = '0;
                n_clr_row     = fcpt_pkg::ROW_W'(r_clr_row + 1'b1);
                if (r_clr_row == fcpt_pkg::ROW_W'(fcpt_pkg::ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_kind  = w_kind;
                    n_ok    = w_acc_ok;
                    n_off   = w_off;
                    n_size  = w_size;
                    n_wdata = w_wdata;
                    n_step  = (|w_cycles[63:32]) ? 32'hFFFF_FFFF : w_cycles[31:0];
                    n_ch    = w_ch;
                    n_idx   = '0;
                    n_flags = '0;
                    n_state = S_WORK;
                    unique case (w_kind)
                        fcpt_pkg::K_STRD: begin
                            w_st_req.rd   = 1'b1;
                            w_st_req.off  = w_off;
                            w_st_req.size = w_size;
                        end
                        fcpt_pkg::K_CHRD, fcpt_pkg::K_CHRL, fcpt_pkg::K_CHCT: begin
                            w_ch_re    = 1'b1;
                            w_ch_raddr = w_ch;
                        end
                        fcpt_pkg::K_SETEN, fcpt_pkg::K_CLREN, fcpt_pkg::K_TICK: begin
                            w_ch_re    = 1'b1;
                            w_ch_raddr = '0;
                            n_state    = S_SWEEP;
                        end
                        default: begin
                            n_state = S_WORK;
                        end
                    endcase
                end
            end
            // Finish a single access once the output register is free
            S_WORK: begin
                if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {1'b0, r_ok, 32'h0};
                    n_state  = S_IDLE;
                    unique case (r_kind)
                        fcpt_pkg::K_STRD: begin
                            n_odata[31:0] = w_st_rdata;
                        end
                        fcpt_pkg::K_STWR: begin
                            w_st_req.wr    = 1'b1;
                            w_st_req.off   = r_off;
                            w_st_req.size  = r_size;
                            w_st_req.wdata = r_wdata;
                        end
                        fcpt_pkg::K_CHRD: begin
                            priority if (r_off[3:0] == fcpt_pkg::CO_RELOAD) begin
                                n_odata[31:0] = w_ch_q.reload;
                            end else if (r_off[3:0] == fcpt_pkg::CO_COUNT) begin
                                n_odata[31:0] = w_ch_q.count;
                            end else begin
                                n_odata[31:0] = w_ch_q.control;
                            end
                        end
                        fcpt_pkg::K_CHRL, fcpt_pkg::K_CHCT: begin
                            w_ch_we    = 1'b1;
                            w_ch_waddr = r_ch;
                        end
                        // Write-one-to-clear touches only the low status byte
                        fcpt_pkg::K_MSRCLR: begin
                            w_st_req.wr    = 1'b1;
                            w_st_req.off   = fcpt_pkg::OFF_MSR;
                            w_st_req.size  = 3'd1;
                            w_st_req.wdata = 32'(r_b0c & ~8'(w_mask));
                        end
                        default: begin
                            n_odata = {1'b0, r_ok, 32'h0};
                        end
                    endcase
                end
            end
            // One channel per cycle, the last once the output is free: write back, read next
            S_SWEEP: begin
                if (!w_last || w_slot_free) begin
                    w_ch_we    = 1'b1;
                    w_ch_waddr = r_idx;
                    n_flags    = w_flags_new;
                    if (!w_last) begin
                        w_ch_re    = 1'b1;
                        w_ch_raddr = fcpt_pkg::CH_W'(r_idx + 1'b1);
                        n_idx      = fcpt_pkg::CH_W'(r_idx + 1'b1);
                    end else begin
                        n_ovalid = 1'b1;
                        n_odata  = {1'b0, r_ok, 32'h0};
                        n_state  = S_IDLE;
                        if (r_kind == fcpt_pkg::K_TICK) begin
                            w_st_req.wr    = 1'b1;
                            w_st_req.off   = fcpt_pkg::OFF_MSR;
                            w_st_req.size  = 3'd1;
                            w_st_req.wdata = 32'(w_msr_new);
                            n_odata[33]    = ((w_msr_new[3:0] & r_mier) != 4'h0);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Shadow copies of the store bytes that control ticks, kept on every store write
    always_comb begin
        logic [12:0] w_baddr;
        n_mcr0  = r_mcr0;
        n_b0c   = r_b0c;
        n_mier  = r_mier;
        w_baddr = '0;
        for (int k = 0; k < 4; k++) begin
            w_baddr = 13'(w_st_req.off) + 13'(k);
            if (w_st_req.wr && (3'(k) < w_st_req.size)) begin
                if (w_baddr == 13'(fcpt_pkg::OFF_MCR)) begin
                    n_mcr0 = w_st_req.wdata[8*k];
                end
                if (w_baddr == 13'(fcpt_pkg::OFF_MSR)) begin
                    n_b0c = w_st_req.wdata[8*k +: 8];
                end
                if (w_baddr == 13'(fcpt_pkg::OFF_MIER)) begin
                    n_mier = w_st_req.wdata[8*k +: 4];
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
            r_ovalid  <= 1'b0;
            r_mcr0    <= 1'b0;
            r_b0c     <= 8'h00;
            r_mier    <= 4'h0;
        end else begin
            r_state   <= n_state;
            r_clr_row <= n_clr_row;
            r_ovalid  <= n_ovalid;
            r_mcr0    <= n_mcr0;
            r_b0c     <= n_b0c;
            r_mier    <= n_mier;
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_kind  <= n_kind;
        r_ok    <= n_ok;
        r_off   <= n_off;
        r_size  <= n_size;
        r_wdata <= n_wdata;
        r_step  <= n_step;
        r_ch    <= n_ch;
        r_idx   <= n_idx;
        r_flags <= n_flags;
    end

    fcpt_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_st_req),
        .o_rdata (w_st_rdata)
    );

    fcpt_ram #(
        .WIDTH ($bits(fcpt_pkg::t_chan)),
        .DEPTH (fcpt_pkg::CHANNELS)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (w_ch_we),
        .i_waddr (w_ch_waddr),
        .i_wdata (w_ch_wdata),
        .i_re    (w_ch_re),
        .i_raddr (w_ch_raddr),
        .o_rdata (w_ch_rdata)
    );

    fcpt_chan_upd u_upd (
        .i_kind (r_kind),
        .i_ch   (w_ch_q),
        .i_data (r_wdata),
        .i_step (r_step),
        .i_sel  (w_mask[r_idx]),
        .o_ch   (w_upd),
        .o_flag (w_flag)
    );

    // The store never reads and writes in one cycle
    a_st_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_st_req.rd && w_st_req.wr))
        else $error("store read and write in the same cycle");

    // No result appears during the clearing pass
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_ovalid)
        else $error("result during clearing pass");

    // A tick never reports an accepted access
    a_irq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odata[33]) |-> !r_odata[32])
        else $error("irq_set together with ok");

    // Sweep index stays on a real channel
    a_sweep_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_idx <= LAST_CH))
        else $error("sweep index out of range");

    // A result is only produced out of a working state
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_WORK || $past(r_state) == S_SWEEP))
        else $error("result without work");

endmodule

// File: bench/timer_checker.sv
// Checker for the periodic timer: predicts each result and compares it.
`timescale 1ns / 100ps

module timer_checker
    import fcpt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_tvalid,
    input  logic             i_in_tready,
    // offset[11:0], access_size[14:12], write_data[46:15], tick_cycles[110:47],
    // clock_ready[111]
    input  logic [IN_W-1:0]  i_in_tdata,
    // op[1:0]
    input  logic [1:0]       i_in_tuser,
    input  logic             i_out_tvalid,
    input  logic             i_out_tready,
    // read_data[31:0], ok[32], irq_set[33], zero pad[39:34]
    input  logic [OUT_W-1:0] i_out_tdata,
    output int               o_fail_count,
    output int               o_pending
);

    // Packed to match the low bits of the result tdata
    typedef struct packed {
        logic        irq;
        logic        ok;
        logic [31:0] rdata;
    } t_result;

    // Mirror of the timer state
    logic [7:0]  store_mem  [REGION_BYTES];
    logic [31:0] reload_r   [CHANNELS];
    logic [31:0] count_r    [CHANNELS];
    logic [31:0] ctrl_r     [CHANNELS];

    t_result expected_results [$];

    function automatic logic [31:0] load_word(logic [11:0] off);
        return {store_mem[off + 3], store_mem[off + 2], store_mem[off + 1], store_mem[off]};
    endfunction

    function automatic void store_word(logic [11:0] off, logic [31:0] v);
        for (int k = 0; k < 4; k++) store_mem[int'(off) + k] = v[8*k +: 8];
    endfunction

    // Applies one item to the mirrored state and returns its result
    function automatic t_result predict_timer(t_op op, logic [11:0] off, logic [2:0] size,
                                              logic [31:0] wdata, logic [63:0] cycles,
                                              logic ready);
        t_result     res;
        logic [31:0] step;
        logic [31:0] msr;
        logic [3:0]  mier;
        logic [11:0] rel;
        logic [3:0]  co;
        int          ch;
        bit          done;
        res  = '0;
        done = 1'b0;
        if (op == OP_RD || op == OP_WR) begin
            if (size >= 3'd1 && size <= 3'd4 && ready &&
                int'(off) + int'(size) <= REGION_BYTES) begin
                res.ok = 1'b1;
                // full-word channel register access
                if (size == 3'd4 && off >= CH_BASE && off < CH_END) begin
                    rel = off - CH_BASE;
                    ch  = int'(rel[11:4]);
                    co  = rel[3:0];
                    if (op == OP_RD) begin
                        case (co)
                            CO_RELOAD: begin res.rdata = reload_r[ch]; done = 1'b1; end
                            CO_COUNT:  begin res.rdata = count_r[ch];  done = 1'b1; end
                            CO_CTRL:   begin res.rdata = ctrl_r[ch];   done = 1'b1; end
                            default: ;
                        endcase
                    end else if (co == CO_RELOAD) begin
                        reload_r[ch] = wdata;
                        if (!ctrl_r[ch][EN_BIT]) count_r[ch] = wdata;
                        done = 1'b1;
                    end else if (co == CO_CTRL) begin
                        ctrl_r[ch] = wdata;
                        if (wdata[EN_BIT] && count_r[ch] == 32'd0) count_r[ch] = reload_r[ch];
                        done = 1'b1;
                    end
                end
                // status clear and enable masks
                if (!done && op == OP_WR && size == 3'd4) begin
                    if (off == OFF_MSR) begin
                        store_word(OFF_MSR, load_word(OFF_MSR) & ~{28'd0, wdata[3:0]});
                        done = 1'b1;
                    end else if (off == OFF_SETTEN) begin
                        for (int k = 0; k < CHANNELS; k++) begin
                            if (wdata[k]) begin
                                ctrl_r[k][EN_BIT] = 1'b1;
                                if (count_r[k] == 32'd0) count_r[k] = reload_r[k];
                            end
                        end
                        done = 1'b1;
                    end else if (off == OFF_CLRTEN) begin
                        for (int k = 0; k < CHANNELS; k++)
                            if (wdata[k]) ctrl_r[k][EN_BIT] = 1'b0;
                        done = 1'b1;
                    end
                end
                // everything else hits the byte store
                if (!done) begin
                    for (int k = 0; k < int'(size); k++) begin
                        if (op == OP_RD) res.rdata[8*k +: 8] = store_mem[int'(off) + k];
                        else store_mem[int'(off) + k] = wdata[8*k +: 8];
                    end
                end
            end
        end else if (op == OP_TICK) begin
            step = (|cycles[63:32]) ? 32'hFFFF_FFFF : cycles[31:0];
            if (ready && store_mem[OFF_MCR][0] && step != 32'd0) begin
                msr  = load_word(OFF_MSR);
                mier = store_mem[OFF_MIER][3:0];
                for (int k = 0; k < CHANNELS; k++) begin
                    if (ctrl_r[k][EN_BIT] && !ctrl_r[k][CHAIN_BIT]) begin
                        if (count_r[k] > step) begin
                            count_r[k] = count_r[k] - step;
                        end else begin
                            count_r[k] = reload_r[k];
                            msr[k]     = 1'b1;
                        end
                    end
                end
                store_word(OFF_MSR, msr);
                res.irq = |(msr[3:0] & mier);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // Result side first, then the new item, so a same-edge pair stays ordered
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < REGION_BYTES; k++) store_mem[k] = 8'd0;
            for (int k = 0; k < CHANNELS; k++) begin
                reload_r[k] = 32'd0;
                count_r[k]  = 32'd0;
                ctrl_r[k]   = 32'd0;
            end
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got = t_result'(i_out_tdata[33:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result transfer %h", i_out_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (got.rdata !== want.rdata)
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  got.rdata, want.rdata));
                    if (got.ok !== want.ok)
                        report_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
                    if (got.irq !== want.irq)
                        report_mismatch($sformatf("irq_set %b, expected %b",
                                                  got.irq, want.irq));
                end
            end
            if (i_in_tvalid && i_in_tready)
                expected_results.push_back(predict_timer(t_op'(i_in_tuser), i_in_tdata[11:0],
                                                         i_in_tdata[14:12], i_in_tdata[46:15],
                                                         i_in_tdata[110:47], i_in_tdata[111]));
        end
        o_pending = expected_results.size();
    end

endmodule

// File: bench/tb.sv
// Testbench top for the periodic timer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb;
    import fcpt_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_GAP      = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 6000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        t_op         op;
        logic [11:0] off;
        logic [2:0]  size;
        logic [31:0] wdata;
        logic [63:0] cycles;
        logic        ready;
    } t_item;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [IN_W-1:0]  s_data  = '0;
    logic [1:0]       s_user  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [OUT_W-1:0] m_data;

    int n_fail;
    int n_pending;
    int stall_cycles = 0;
    bit send_idle    = 1'b1;
    bit rcv_idle     = 1'b1;
    bit hold_req     = 1'b0;

    always #1 clk = ~clk;

    four_channel_periodic_timer uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    timer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (s_valid),
        .i_in_tready  (s_ready),
        .i_in_tdata   (s_data),
        .i_in_tuser   (s_user),
        .i_out_tvalid (m_valid),
        .i_out_tready (m_ready),
        .i_out_tdata  (m_data),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    function automatic int pick_gap(bit idle);
        return idle ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic t_item mk(t_op op, logic [11:0] off, logic [2:0] size,
                                 logic [31:0] wdata, logic [63:0] cycles, logic ready);
        t_item it;
        it.op     = op;
        it.off    = off;
        it.size   = size;
        it.wdata  = wdata;
        it.cycles = cycles;
        it.ready  = ready;
        return it;
    endfunction

    // Starts and ends at a falling edge; valid stays high after the transfer
    task automatic send_item(input t_item it);
        int gap;
        gap = pick_gap(send_idle);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= it.op;
        s_data  <= {it.ready, it.cycles, it.wdata, it.size, it.off};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly well-formed timer traffic, with some noise and broken accesses
    task automatic make_random_item(output t_item it);
        int r;
        int ch;
        int pick;
        r         = $urandom_range(0, 99);
        ch        = $urandom_range(0, CHANNELS - 1);
        pick      = $urandom_range(0, 7);
        it.op     = OP_RD;
        it.off    = 12'($urandom);
        it.size   = 3'd4;
        it.wdata  = $urandom;
        it.cycles = {$urandom, $urandom};
        it.ready  = ($urandom_range(0, 31) != 0);
        if (r < 30) begin
            it.op = OP_TICK;
            case (pick)
                0: it.cycles = 64'd0;
                1: ;  // full 64-bit value, almost always saturates
                2: it.cycles = {32'd0, $urandom};
                default: it.cycles = 64'($urandom_range(1, 24));
            endcase
        end else if (r < 45) begin
            it.op = OP_WR;
            if (pick < 3) begin
                it.off = CH_BASE + 12'(16 * ch) + CO_RELOAD;
                if (pick != 0) it.wdata = $urandom_range(0, 40);
            end else if (pick < 7) begin
                it.off = CH_BASE + 12'(16 * ch) + CO_CTRL;
                if (pick != 6)
                    it.wdata = {30'd0, 1'($urandom_range(0, 5) == 0),
                                1'($urandom_range(0, 3) != 0)};
            end else begin
                // count offset writes land in the byte store
                it.off = CH_BASE + 12'(16 * ch) + CO_COUNT;
            end
        end else if (r < 60) begin
            it.off = CH_BASE + 12'(16 * ch) + 12'(4 * $urandom_range(0, 3));
        end else if (r < 70) begin
            it.op = OP_WR;
            case (pick % 3)
                0: it.off = OFF_MSR;
                1: it.off = OFF_SETTEN;
                default: it.off = OFF_CLRTEN;
            endcase
        end else if (r < 76) begin
            it.op   = OP_WR;
            it.size = 3'($urandom_range(1, 4));
            if (pick < 5) begin
                it.off      = OFF_MCR;
                it.wdata[0] = (pick != 0);
            end else begin
                it.off = OFF_MIER;
            end
        end else if (r < 80) begin
            it.size = 3'($urandom_range(1, 4));
            case (pick % 3)
                0: it.off = OFF_MCR;
                1: it.off = OFF_MSR;
                default: it.off = OFF_MIER;
            endcase
        end else if (r < 83) begin
            it.op   = OP_NOP;
            it.size = 3'($urandom_range(0, 7));
        end else if (r < 88) begin
            // random, often misaligned or narrow, access inside the channel window
            it.op   = t_op'($urandom_range(0, 1));
            it.off  = CH_BASE + 12'($urandom_range(0, 16 * CHANNELS - 1));
            it.size = 3'($urandom_range(1, 4));
        end else begin
            it.op   = t_op'($urandom_range(0, 1));
            it.size = 3'($urandom_range(0, 7));
            if (pick == 0) it.off = 12'(REGION_BYTES - $urandom_range(1, 5));
            else if (pick < 3) it.off = 12'($urandom_range(0, 'h5F));
        end
    endtask

    // Result side: random hold-offs, plus one long stall on request
    initial begin : receiver
        int gap;
        int n_results;
        n_results = 0;
        @(negedge clk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = pick_gap(rcv_idle);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!m_valid) @(posedge clk);
            @(negedge clk);
            n_results++;
            if (n_results % 64 == 0) rcv_idle = ($urandom_range(0, 3) != 0);
        end
    end

    // No transfer on either side for too long ends the run
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        t_item directed [$];
        t_item it;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // module on, all interrupts enabled, a few channels set up
        directed.push_back(mk(OP_RD,   OFF_MCR,  3'd1, 32'h0,         64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   OFF_MCR,  3'd1, 32'h0000_0001, 64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   OFF_MIER, 3'd1, 32'h0000_000F, 64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   CH_BASE + 12'h00 + CO_RELOAD, 3'd4, 32'd3, 64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   CH_BASE + 12'h10 + CO_RELOAD, 3'd4, 32'hFFFF_FFFF,
                              64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   CH_BASE + 12'h30 + CO_RELOAD, 3'd4, 32'd5, 64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   CH_BASE + 12'h00 + CO_CTRL, 3'd4, 32'd1, 64'd0, 1'b1));
        // zero reload: this channel expires on every tick
        directed.push_back(mk(OP_WR,   CH_BASE + 12'h20 + CO_CTRL, 3'd4, 32'd1, 64'd0, 1'b1));
        // chained channel is skipped by the count-down
        directed.push_back(mk(OP_WR,   CH_BASE + 12'h30 + CO_CTRL, 3'd4, 32'd3, 64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   OFF_SETTEN, 3'd4, 32'hFFFF_FFF2, 64'd0, 1'b1));
        // idle tick, single-step tick, saturating tick
        directed.push_back(mk(OP_TICK, 12'h0, 3'd0, 32'h0, 64'd0, 1'b1));
        directed.push_back(mk(OP_TICK, 12'h0, 3'd0, 32'h0, 64'd1, 1'b1));
        directed.push_back(mk(OP_TICK, 12'hFFF, 3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                              1'b1));
        directed.push_back(mk(OP_RD,   CH_BASE + 12'h10 + CO_COUNT, 3'd4, 32'h0, 64'd0, 1'b1));
        directed.push_back(mk(OP_RD,   OFF_MSR, 3'd4, 32'h0, 64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   OFF_MSR, 3'd4, 32'hFFFF_FFF5, 64'd0, 1'b1));
        // count offset write, narrow and misaligned channel reads go to the store
        directed.push_back(mk(OP_WR,   CH_BASE + CO_COUNT, 3'd4, 32'hA5A5_5A5A, 64'd0, 1'b1));
        directed.push_back(mk(OP_RD,   CH_BASE + CO_COUNT, 3'd2, 32'h0, 64'd0, 1'b1));
        directed.push_back(mk(OP_RD,   CH_BASE + 12'h1, 3'd4, 32'h0, 64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   OFF_CLRTEN, 3'd4, 32'h0000_000F, 64'd0, 1'b1));
        // clock off, bad sizes, out of range, last word, no operation
        directed.push_back(mk(OP_RD,   CH_BASE + CO_RELOAD, 3'd4, 32'h0, 64'd0, 1'b0));
        directed.push_back(mk(OP_TICK, 12'h0, 3'd0, 32'h0, 64'd7, 1'b0));
        directed.push_back(mk(OP_WR,   12'h100, 3'd0, 32'hFFFF_FFFF, 64'd0, 1'b1));
        directed.push_back(mk(OP_RD,   12'h100, 3'd7, 32'h0, 64'd0, 1'b1));
        directed.push_back(mk(OP_RD,   12'hFFE, 3'd4, 32'h0, 64'd0, 1'b1));
        directed.push_back(mk(OP_WR,   12'hFFC, 3'd4, 32'hDEAD_BEEF, 64'd0, 1'b1));
        directed.push_back(mk(OP_NOP,  12'hFFF, 3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                              1'b1));
        foreach (directed[i]) send_item(directed[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 128 == 0) send_idle = ($urandom_range(0, 3) != 0);
            // long receiver stall while items keep coming
            if (i == 500) hold_req = 1'b1;
            // let the block drain completely before going on
            if (i == 1200) begin
                s_valid <= 1'b0;
                wait (n_pending == 0);
                @(negedge clk);
            end
            make_random_item(it);
            send_item(it);
        end
        s_valid <= 1'b0;

        wait (n_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (n_fail == 0 && n_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
